// ===== hdl/rna_pkg.sv =====
package rna_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } rna_cmd_t;

  typedef struct packed {
    rna_cmd_t           command;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rna_in_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic               den_zero;
  } rna_out_t;

endpackage

// ===== hdl/rational_arith_normalize.sv =====
// A zero denominator or zero value ends right after the sum; every other result goes
// through the binary gcd loop and the divider.
// Three products share one 32x32 multiplier, one sign/magnitude add,
// a shift-subtract gcd loop (one step a cycle), then two restoring divider lanes.
// One transaction at a time; busy stays high until done; results can't stall.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
module rational_arith_normalize import rna_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  rna_in_t  operands,
  output logic     done,
  output rna_out_t result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_GCD,
    S_DIV
  } state_t;

  state_t state;

  rna_cmd_t    cmd;
  logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;
  logic        an_neg, ad_neg, bn_neg, bd_neg;
  logic [1:0]  mstep;

  logic [63:0] p0, p1, den;
  logic        p0_neg, p1_neg, den_neg;
  logic [63:0] num_mag;
  logic        res_neg;

  logic [63:0] u, v, g;
  logic [5:0]  k;

  logic [63:0] qn, qd, remn, remd;
  logic [5:0]  cnt;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    mag32 = x[31] ? (~x + 32'd1) : x;
  endfunction

  // shared multiplier, operands picked by step
  logic [31:0] mul_a, mul_b;
  logic        mul_neg;
  logic [63:0] mul_p;

  always_comb begin
    case (mstep)
      2'd0: begin
        mul_a   = an_mag;
        mul_b   = (cmd == CMD_MUL) ? bn_mag : bd_mag;
        mul_neg = an_neg ^ ((cmd == CMD_MUL) ? bn_neg : bd_neg);
      end
      2'd1: begin
        mul_a   = bn_mag;
        mul_b   = ad_mag;
        mul_neg = bn_neg ^ ad_neg ^ (cmd == CMD_SUB);
      end
      default: begin
        mul_a   = ad_mag;
        mul_b   = (cmd == CMD_DIV) ? bn_mag : bd_mag;
        mul_neg = ad_neg ^ ((cmd == CMD_DIV) ? bn_neg : bd_neg);
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // signed-magnitude sum of the two numerator terms for add/sub; p0 alone for mul/div
  logic [63:0] sum_mag;
  logic        sum_neg;

  always_comb begin
    if (cmd inside {CMD_ADD, CMD_SUB}) begin
      if (p0_neg == p1_neg) begin
        sum_mag = p0 + p1;
        sum_neg = p0_neg;
      end else if (p0 >= p1) begin
        sum_mag = p0 - p1;
        sum_neg = p0_neg;
      end else begin
        sum_mag = p1 - p0;
        sum_neg = p1_neg;
      end
    end else begin
      sum_mag = p0;
      sum_neg = p0_neg;
    end
  end

  // binary gcd step
  logic        gcd_gt;
  logic [63:0] gcd_diff;

  assign gcd_gt   = u > v;
  assign gcd_diff = gcd_gt ? (u - v) : (v - u);

  // two restoring divider lanes
  logic [63:0] rn_sh, rd_sh, remn_next, remd_next, qn_next, qd_next;
  logic        rn_ge, rd_ge;

  always_comb begin
    rn_sh     = {remn[62:0], qn[63]};
    rd_sh     = {remd[62:0], qd[63]};
    rn_ge     = rn_sh >= g;
    rd_ge     = rd_sh >= g;
    remn_next = rn_ge ? (rn_sh - g) : rn_sh;
    remd_next = rd_ge ? (rd_sh - g) : rd_sh;
    qn_next   = {qn[62:0], rn_ge};
    qd_next   = {qd[62:0], rd_ge};
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      mstep <= 2'd0;
    end else begin
      case (state)
        // every done strobe returns here, so idle clears it
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cmd    <= operands.command;
            an_mag <= mag32(operands.a_num);
            ad_mag <= mag32(operands.a_den);
            bn_mag <= mag32(operands.b_num);
            bd_mag <= mag32(operands.b_den);
            an_neg <= operands.a_num[31];
            ad_neg <= operands.a_den[31];
            bn_neg <= operands.b_num[31];
            bd_neg <= operands.b_den[31];
            mstep  <= 2'd0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0: begin
              p0     <= mul_p;
              p0_neg <= mul_neg;
            end
            2'd1: begin
              p1     <= mul_p;
              p1_neg <= mul_neg;
            end
            default: begin
              den     <= mul_p;
              den_neg <= mul_neg;
            end
          endcase
          if (mstep == 2'd2) begin
            state <= S_SUM;
          end
          mstep <= mstep + 2'd1;
        end
        S_SUM: begin
          num_mag <= sum_mag;
          res_neg <= sum_neg ^ den_neg;
          if (den == 64'd0) begin
            result.res_num  <= 64'sd0;
            result.res_den  <= 63'd0;
            result.den_zero <= 1'b1;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else if (sum_mag == 64'd0) begin
            result.res_num  <= 64'sd0;
            result.res_den  <= 63'd1;
            result.den_zero <= 1'b0;
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            u     <= sum_mag;
            v     <= den;
            k     <= 6'd0;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (u == v) begin
            g     <= u << k;
            qn    <= num_mag;
            qd    <= den;
            remn  <= 64'd0;
            remd  <= 64'd0;
            cnt   <= 6'd0;
            state <= S_DIV;
          end else if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + 6'd1;
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (gcd_gt) begin
            u <= gcd_diff >> 1;
          end else begin
            v <= gcd_diff >> 1;
          end
        end
        S_DIV: begin
          remn <= remn_next;
          remd <= remd_next;
          qn   <= qn_next;
          qd   <= qd_next;
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            result.res_num  <= res_neg ? (64'sd0 - $signed(qn_next)) : $signed(qn_next);
            result.res_den  <= qd_next[62:0];
            result.den_zero <= 1'b0;
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_zero_den: assert property (@(posedge clk) disable iff (rst)
    (done && result.den_zero) |-> (result.res_num == 64'sd0 && result.res_den == 63'd0))
    else $error("zero denominator result not 0/0");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.den_zero) |-> (result.res_den != 63'd0))
    else $error("valid result with zero denominator");

endmodule
